### rtl/nnes_pkg.sv
// Package for the nearest node error search block: sizes, op codes, status codes, register addresses, state enum.
// No dependencies.
`default_nettype none
package nnes_pkg;
    localparam int MAX_NODES_DEF  = 1024;
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int BIAS_PERIOD    = 10;
    localparam int INDEX_BITS     = 10;
    localparam int COUNT_BITS     = 11;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_QUERY  = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic [1:0] REG_BIAS   = 2'd0;
    localparam logic [1:0] REG_GOAL_X = 2'd1;
    localparam logic [1:0] REG_GOAL_Y = 2'd2;
    localparam logic [1:0] REG_GOAL_A = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_FETCH, S_FETCH2, S_OUT
    } state_t;
endpackage
`default_nettype wire

### rtl/nnes_cell.sv
// One compare cell: adds a squared error term; the last cell also keeps the running minimum.
// Cells chain x, y, area; depends on nnes_pkg only through parameters handed down.
`default_nettype none
module nnes_cell #(
    parameter int CB = 24,
    parameter int IB = 10,
    parameter bit LAST = 1'b0
) (
    input  wire logic                aclk,
    input  wire logic                start,
    input  wire logic                in_valid,
    input  wire logic [IB-1:0]       in_idx,
    input  wire logic signed [CB-1:0] coord,
    input  wire logic signed [CB-1:0] target,
    input  wire logic [2*CB+1:0]     in_sum,
    output logic                     out_valid,
    output logic [IB-1:0]            out_idx,
    output logic [2*CB+1:0]          out_sum,
    output logic [IB-1:0]            best_idx
);
    localparam int SW = 2 * CB + 2;
    logic signed [CB:0]   diff;
    logic [CB:0]          mag;
    logic [SW-1:0]        sq;
    logic [SW-1:0]        sum;
    logic [SW-1:0]        best_sum_reg;
    logic                 seen_reg;
    logic [IB-1:0]        best_idx_reg;

    assign diff = {coord[CB-1], coord} - {target[CB-1], target};
    assign mag  = diff[CB] ? (CB+1)'(-diff) : diff;
    assign sq   = SW'(mag) * SW'(mag);
    assign sum  = in_sum + sq;

    always_ff @(posedge aclk) begin
        out_valid <= in_valid;
        out_idx   <= in_idx;
        out_sum   <= sum;
        if (start) begin
            seen_reg <= 1'b0;
        end else if (LAST && in_valid && (!seen_reg || sum < best_sum_reg)) begin
            seen_reg     <= 1'b1;
            best_sum_reg <= sum;
            best_idx_reg <= in_idx;
        end
    end
    assign best_idx = best_idx_reg;
endmodule
`default_nettype wire

### rtl/nearest_node_error_search_top.sv
// Top level: node store memories, control sequencer and a chain of three compare cells.
// Depends on nnes_pkg and nnes_cell.
// One item at a time: the next beat can be taken the cycle after the result leaves;
// a query scans the stored nodes, one node a cycle.
// Reset: aresetn synchronous active low clears node count, config registers and the sequencer.
`default_nettype none
module nearest_node_error_search_top #(
    parameter int COORD_BITS = nnes_pkg::COORD_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // func[1:0], iteration[33:2], pos_x, pos_y, pos_area, zero fill
    input  wire logic [((2+32+3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], nearest_index[11:2], err_x, err_y, err_area, node_total, zero fill
    output logic [((2+10+3*(COORD_BITS+1)+11+7)/8)*8-1:0] m_tdata
);
    localparam int MAX_NODES = nnes_pkg::MAX_NODES_DEF;
    localparam int CB = COORD_BITS;
    localparam int AB = $clog2(MAX_NODES);
    localparam int NB = AB + 1;
    localparam int IB = nnes_pkg::INDEX_BITS;
    localparam int SW = 2 * CB + 2;
    localparam int OW = ((2+10+3*(COORD_BITS+1)+11+7)/8)*8;
    localparam int OP = 12 + 3 * (CB + 1) + 11;

    logic [3:0]          bias_reg;
    logic signed [CB-1:0] gx_reg, gy_reg, ga_reg;
    logic signed [CB-1:0] tx_reg, ty_reg;
    logic [NB-1:0]       count_reg;
    logic [NB-1:0]       scan_reg;
    nnes_pkg::state_t    state_reg, state_next;
    logic [OW-1:0]       out_reg;
    logic [OW-1:0]       out_next;

    logic signed [CB-1:0] mx [MAX_NODES];
    logic signed [CB-1:0] my [MAX_NODES];
    logic signed [CB-1:0] ma [MAX_NODES];
    logic signed [CB-1:0] rx_reg, ry_reg, ra_reg;
    logic [AB-1:0]       raddr;
    logic                rvalid_reg;
    logic [AB-1:0]       ridx_reg;
    logic [3:0]          drain_reg;

    logic [1:0]          func;
    logic [31:0]         iter;
    logic signed [CB-1:0] px, py, pa;
    assign func = s_tdata[1:0];
    assign iter = s_tdata[33:2];
    assign px   = s_tdata[34+:CB];
    assign py   = s_tdata[34+CB+:CB];
    assign pa   = s_tdata[34+2*CB+:CB];

    function automatic logic [3:0] iter_mod10(input logic [31:0] v);
        logic [6:0] nib_sum;
        logic [4:0] fold;
        logic [2:0] m5;
        nib_sum = 7'(v[3:0]) + 7'(v[7:4]) + 7'(v[11:8]) + 7'(v[15:12])
                + 7'(v[19:16]) + 7'(v[23:20]) + 7'(v[27:24]) + 7'(v[31:28]);
        fold = 5'(nib_sum[6:4]) + 5'(nib_sum[3:0]);
        fold = (fold >= 5'd15) ? fold - 5'd15 : fold;
        fold = (fold >= 5'd10) ? fold - 5'd10 : fold;
        fold = (fold >= 5'd5)  ? fold - 5'd5  : fold;
        m5 = fold[2:0];
        return (m5[0] == v[0]) ? 4'(m5) : 4'(m5) + 4'd5;
    endfunction

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == nnes_pkg::S_IDLE) && !m_tvalid;
    wire in_acc = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_reg <= '0; gx_reg <= '0; gy_reg <= '0; ga_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                nnes_pkg::REG_BIAS:   bias_reg <= cfg_data[3:0];
                nnes_pkg::REG_GOAL_X: gx_reg   <= cfg_data[CB-1:0];
                nnes_pkg::REG_GOAL_Y: gy_reg   <= cfg_data[CB-1:0];
                nnes_pkg::REG_GOAL_A: ga_reg   <= cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    wire start = in_acc && func == nnes_pkg::FUNC_QUERY;
    logic [AB-1:0] best_idx;

    always_comb begin
        state_next = state_reg;
        raddr = scan_reg[AB-1:0];
        unique case (state_reg)
            nnes_pkg::S_IDLE:
                if (start && count_reg != '0) state_next = nnes_pkg::S_SCAN;
            nnes_pkg::S_SCAN:
                if (scan_reg == count_reg - NB'(1)) state_next = nnes_pkg::S_DRAIN;
            nnes_pkg::S_DRAIN:
                if (drain_reg == 4'd4) state_next = nnes_pkg::S_FETCH;
            nnes_pkg::S_FETCH: begin
                raddr = best_idx;
                state_next = nnes_pkg::S_FETCH2;
            end
            nnes_pkg::S_FETCH2: begin
                raddr = best_idx;
                state_next = nnes_pkg::S_OUT;
            end
            nnes_pkg::S_OUT:    state_next = nnes_pkg::S_IDLE;
            default:            state_next = nnes_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        out_next = out_reg;
        if (in_acc) begin
            out_next = '0;
            unique case (nnes_pkg::func_t'(func))
                nnes_pkg::FUNC_INSERT: begin
                    if (count_reg == NB'(MAX_NODES)) begin
                        out_next[1:0] = nnes_pkg::ST_FULL;
                        out_next[OP-11+:11] = 11'(count_reg);
                    end else begin
                        out_next[OP-11+:11] = 11'(count_reg + NB'(1));
                    end
                end
                nnes_pkg::FUNC_CLEAR: ;
                nnes_pkg::FUNC_QUERY: begin
                    out_next[OP-11+:11] = 11'(count_reg);
                    if (count_reg == '0) out_next[1:0] = nnes_pkg::ST_EMPTY;
                end
                nnes_pkg::FUNC_NOP: out_next[OP-11+:11] = 11'(count_reg);
                default: ;
            endcase
        end
        if (state_reg == nnes_pkg::S_OUT) begin
            out_next[11:2]          = IB'(best_idx);
            out_next[12+:CB+1]      = {rx_reg[CB-1], rx_reg} - {tx_reg[CB-1], tx_reg};
            out_next[13+CB+:CB+1]   = {ry_reg[CB-1], ry_reg} - {ty_reg[CB-1], ty_reg};
            out_next[14+2*CB+:CB+1] = {ra_reg[CB-1], ra_reg} - {ga_reg[CB-1], ga_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nnes_pkg::S_IDLE;
            count_reg <= '0;
            m_tvalid  <= 1'b0;
            rvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rvalid_reg <= state_reg == nnes_pkg::S_SCAN;
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            if (in_acc) begin
                unique case (nnes_pkg::func_t'(func))
                    nnes_pkg::FUNC_INSERT: begin
                        if (count_reg != NB'(MAX_NODES)) count_reg <= count_reg + NB'(1);
                        m_tvalid <= 1'b1;
                    end
                    nnes_pkg::FUNC_CLEAR: begin
                        count_reg <= '0;
                        m_tvalid  <= 1'b1;
                    end
                    nnes_pkg::FUNC_QUERY: begin
                        if (count_reg == '0) m_tvalid <= 1'b1;
                    end
                    nnes_pkg::FUNC_NOP: m_tvalid <= 1'b1;
                    default: ;
                endcase
            end
            if (state_reg == nnes_pkg::S_OUT) m_tvalid <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (in_acc) begin
            scan_reg <= '0;
            if (iter_mod10(iter) >= bias_reg) begin
                tx_reg <= px; ty_reg <= py;
            end else begin
                tx_reg <= gx_reg; ty_reg <= gy_reg;
            end
        end else if (state_reg == nnes_pkg::S_SCAN) begin
            scan_reg <= scan_reg + NB'(1);
        end
        drain_reg <= (state_reg == nnes_pkg::S_DRAIN) ? drain_reg + 4'd1 : 4'd0;
        if (in_acc && func == nnes_pkg::FUNC_INSERT && count_reg != NB'(MAX_NODES)) begin
            mx[count_reg[AB-1:0]] <= px;
            my[count_reg[AB-1:0]] <= py;
            ma[count_reg[AB-1:0]] <= pa;
        end
        rx_reg   <= mx[raddr];
        ry_reg   <= my[raddr];
        ra_reg   <= ma[raddr];
        ridx_reg <= raddr;
    end

    logic          v1, v2, v3;
    logic [AB-1:0] i1, i2, i3;
    logic [SW-1:0] s1, s2, s3;
    logic [AB-1:0] b1, b2;
    logic signed [CB-1:0] my_d, ma_d, ma_d2;

    always_ff @(posedge aclk) begin
        my_d  <= ry_reg;
        ma_d  <= ra_reg;
        ma_d2 <= ma_d;
    end

    nnes_cell #(.CB(CB), .IB(AB), .LAST(1'b0)) u_cell_x (
        .aclk(aclk), .start(start), .in_valid(rvalid_reg), .in_idx(ridx_reg),
        .coord(rx_reg), .target(tx_reg), .in_sum('0),
        .out_valid(v1), .out_idx(i1), .out_sum(s1), .best_idx(b1));
    nnes_cell #(.CB(CB), .IB(AB), .LAST(1'b0)) u_cell_y (
        .aclk(aclk), .start(start), .in_valid(v1), .in_idx(i1),
        .coord(my_d), .target(ty_reg), .in_sum(s1),
        .out_valid(v2), .out_idx(i2), .out_sum(s2), .best_idx(b2));
    nnes_cell #(.CB(CB), .IB(AB), .LAST(1'b1)) u_cell_a (
        .aclk(aclk), .start(start), .in_valid(v2), .in_idx(i2),
        .coord(ma_d2), .target(ga_reg), .in_sum(s2),
        .out_valid(v3), .out_idx(i3), .out_sum(s3), .best_idx(best_idx));

    assign m_tdata = out_reg;
    wire unused_ok = &{1'b0, v3, i3, s3, b1, b2, 1'b0};
endmodule
`default_nettype wire

### rtl/nnes_checker.sv
// Port checker for the nearest node error search top level, bound in below.
// Depends on the top level's ports only.
`default_nettype none
module nnes_port_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second beat taken");
endmodule
bind nearest_node_error_search_top nnes_port_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready));
`default_nettype wire
